[rtl/keypoint_heatmap_mask_render_assert.svh]
// Assertion macros shared by the heat map renderer RTL.
// Each macro checks on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef KEYPOINT_HEATMAP_MASK_RENDER_ASSERT_SVH
`define KEYPOINT_HEATMAP_MASK_RENDER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define KHM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define KHM_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define KHM_ASSERT(name, prop, msg)
`define KHM_ASSERT_NEVER(name, expr, msg)
`endif

`endif

[rtl/khm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package khm_pkg;

  localparam int unsigned KEYPOINTS   = 16;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned MAP_DIM     = 1024;
  localparam int unsigned MAX_RADIUS  = 31;

  // Command queue between front and back, and the result queue. Both depths
  // are powers of two so the pointers wrap on their own.
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int unsigned OUT_DEPTH  = 8;
  localparam int unsigned OUT_AW     = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CW     = $clog2(OUT_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    OP_SET_SIZE    = 2'd0,
    OP_LOAD_KEY    = 2'd1,
    OP_WRITE_TABLE = 2'd2,
    OP_EVAL        = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINARY_MODE = 1'b0,
    CFG_GAUSS_MEAN  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e                op;
    logic [3:0]         slot;
    logic               slot_ok;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [10:0]        width;
    logic [10:0]        height;
    logic [4:0]         outer;
    logic [5:0]         inner;
    logic [9:0]         tab_idx;
    logic               tab_ok;
    logic [15:0]        tab_val;
  } cmd_t;

  typedef struct packed {
    logic signed [10:0] kx;
    logic signed [10:0] ky;
    logic [4:0]         outer;
    logic [5:0]         inner;
  } kp_t;

endpackage

`default_nettype wire

[rtl/khm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module khm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/khm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module khm_front #(
  parameter int unsigned KEYPOINTS   = khm_pkg::KEYPOINTS,
  parameter int unsigned TABLE_DEPTH = khm_pkg::TABLE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [3:0]         key_index_i,
  input  wire logic signed [10:0] pos_x_i,
  input  wire logic signed [10:0] pos_y_i,
  input  wire logic [10:0]        image_width_i,
  input  wire logic [10:0]        image_height_i,
  input  wire logic [4:0]         outer_radius_i,
  input  wire logic [5:0]         inner_radius_i,
  input  wire logic [9:0]         table_index_i,
  input  wire logic [15:0]        table_value_i,
  output logic                    cmd_valid_o,
  input  wire logic               cmd_ready_i,
  output khm_pkg::cmd_t           cmd_o
);

  localparam int unsigned CmdqAw = khm_pkg::CMDQ_AW;
  localparam int unsigned CmdqCw = khm_pkg::CMDQ_CW;

  khm_pkg::cmd_t      cmd_d;
  khm_pkg::cmd_t      cmdq_q [khm_pkg::CMDQ_DEPTH];
  logic [CmdqAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CmdqAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CmdqCw-1:0]  cnt_q, cnt_d;
  logic               push, pop;

  // Range checks and saturation are done here so the back end only executes.
  always_comb begin
    cmd_d.op      = khm_pkg::op_e'(opcode_i);
    cmd_d.slot    = key_index_i;
    cmd_d.slot_ok = 32'(key_index_i) < KEYPOINTS;
    cmd_d.pos_x   = pos_x_i;
    cmd_d.pos_y   = pos_y_i;
    cmd_d.width   = (32'(image_width_i) > khm_pkg::MAP_DIM) ?
                    11'(khm_pkg::MAP_DIM) : image_width_i;
    cmd_d.height  = (32'(image_height_i) > khm_pkg::MAP_DIM) ?
                    11'(khm_pkg::MAP_DIM) : image_height_i;
    cmd_d.outer   = (32'(outer_radius_i) > khm_pkg::MAX_RADIUS) ?
                    5'(khm_pkg::MAX_RADIUS) : outer_radius_i;
    cmd_d.inner   = inner_radius_i;
    cmd_d.tab_idx = table_index_i;
    cmd_d.tab_ok  = 32'(table_index_i) < TABLE_DEPTH;
    cmd_d.tab_val = table_value_i;
  end

  assign in_ready_o  = cnt_q != CmdqCw'(khm_pkg::CMDQ_DEPTH);
  assign cmd_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = cmdq_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmdq_q[wr_ptr_q] <= cmd_d;
    end
  end

endmodule

`default_nettype wire

[rtl/khm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "keypoint_heatmap_mask_render_assert.svh"

module khm_back #(
  parameter int unsigned KEYPOINTS   = khm_pkg::KEYPOINTS,
  parameter int unsigned TABLE_DEPTH = khm_pkg::TABLE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire khm_pkg::cmd_t     cmd_i,
  input  wire logic              binary_mode_i,
  input  wire logic signed [4:0] gauss_mean_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            heat_value_o,
  output logic                   mask_bit_o,
  output logic                   key_valid_o
);

  localparam int unsigned KpAw  = (KEYPOINTS > 1) ? $clog2(KEYPOINTS) : 1;
  localparam int unsigned TbAw  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned KpW   = $bits(khm_pkg::kp_t);
  localparam int unsigned OutAw = khm_pkg::OUT_AW;
  localparam int unsigned OutCw = khm_pkg::OUT_CW;

  typedef struct packed {
    logic [15:0] heat;
    logic        mask;
    logic        valid;
  } res_t;

  // ---------------- Issue ----------------
  logic              issue, issue_eval;
  logic [OutCw-1:0]  res_q, res_d;
  logic [10:0]       cur_w_q, cur_h_q;
  khm_pkg::kp_t      kp_wdata;
  logic [KpW-1:0]    kp_rdata;

  // A pixel request issues only when its result has a reserved slot in the
  // result queue, so the pipeline itself never stalls.
  assign cmd_ready_o = (cmd_i.op != khm_pkg::OP_EVAL) || (res_q < OutCw'(khm_pkg::OUT_DEPTH));
  assign issue       = cmd_valid_i && cmd_ready_o;
  assign issue_eval  = issue && (cmd_i.op == khm_pkg::OP_EVAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w_q <= 11'(khm_pkg::MAP_DIM);
      cur_h_q <= 11'(khm_pkg::MAP_DIM);
    end else if (issue && cmd_i.op == khm_pkg::OP_SET_SIZE) begin
      cur_w_q <= cmd_i.width;
      cur_h_q <= cmd_i.height;
    end
  end

  always_comb begin
    kp_wdata.kx    = cmd_i.pos_x;
    kp_wdata.ky    = cmd_i.pos_y;
    kp_wdata.outer = cmd_i.outer;
    kp_wdata.inner = cmd_i.inner;
  end

  khm_ram #(
    .WIDTH (KpW),
    .DEPTH (KEYPOINTS),
    .AW    (KpAw)
  ) u_kp_ram (
    .clk_i   (clk_i),
    .we_i    (issue && cmd_i.op == khm_pkg::OP_LOAD_KEY && cmd_i.slot_ok),
    .waddr_i (KpAw'(cmd_i.slot)),
    .wdata_i (kp_wdata),
    .re_i    (issue_eval),
    .raddr_i (KpAw'(cmd_i.slot)),
    .rdata_o (kp_rdata)
  );

  // ---------------- Stage 1: bounds and offsets ----------------
  logic               s1_vld_q;
  khm_pkg::op_e       s1_op_q;
  logic               s1_slot_ok_q;
  logic signed [10:0] s1_px_q, s1_py_q;
  logic [10:0]        s1_w_q, s1_h_q;
  logic [9:0]         s1_tidx_q;
  logic               s1_tok_q;
  logic [15:0]        s1_tval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
    end
  end

  // The image size travels with the request, since a later size change may
  // already have issued when this request reaches the bounds check.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_op_q      <= cmd_i.op;
      s1_slot_ok_q <= cmd_i.slot_ok;
      s1_px_q      <= cmd_i.pos_x;
      s1_py_q      <= cmd_i.pos_y;
      s1_w_q       <= cur_w_q;
      s1_h_q       <= cur_h_q;
      s1_tidx_q    <= cmd_i.tab_idx;
      s1_tok_q     <= cmd_i.tab_ok;
      s1_tval_q    <= cmd_i.tab_val;
    end
  end

  khm_pkg::kp_t       kp_rd;
  logic               key_in, pix_in;
  logic signed [11:0] dx, dy;
  logic signed [12:0] ex, ey;

  always_comb begin
    kp_rd  = khm_pkg::kp_t'(kp_rdata);
    key_in = !kp_rd.kx[10] && !kp_rd.ky[10] &&
             ($unsigned(kp_rd.kx) < s1_w_q) && ($unsigned(kp_rd.ky) < s1_h_q);
    pix_in = !s1_px_q[10] && !s1_py_q[10] &&
             ($unsigned(s1_px_q) < s1_w_q) && ($unsigned(s1_py_q) < s1_h_q);
    dx     = {s1_px_q[10], s1_px_q} - {kp_rd.kx[10], kp_rd.kx};
    dy     = {s1_py_q[10], s1_py_q} - {kp_rd.ky[10], kp_rd.ky};
    ex     = {dx[11], dx} - {{8{gauss_mean_i[4]}}, gauss_mean_i};
    ey     = {dy[11], dy} - {{8{gauss_mean_i[4]}}, gauss_mean_i};
  end

  // ---------------- Stage 2: squares ----------------
  logic               s2_vld_q;
  khm_pkg::op_e       s2_op_q;
  logic               s2_key_ok_q, s2_pix_in_q;
  logic signed [11:0] s2_dx_q, s2_dy_q;
  logic signed [12:0] s2_ex_q, s2_ey_q;
  logic [4:0]         s2_outer_q;
  logic [5:0]         s2_inner_q;
  logic [9:0]         s2_tidx_q;
  logic               s2_tok_q;
  logic [15:0]        s2_tval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_op_q     <= s1_op_q;
      s2_key_ok_q <= s1_slot_ok_q && key_in;
      s2_pix_in_q <= pix_in;
      s2_dx_q     <= dx;
      s2_dy_q     <= dy;
      s2_ex_q     <= ex;
      s2_ey_q     <= ey;
      s2_outer_q  <= kp_rd.outer;
      s2_inner_q  <= kp_rd.inner;
      s2_tidx_q   <= s1_tidx_q;
      s2_tok_q    <= s1_tok_q;
      s2_tval_q   <= s1_tval_q;
    end
  end

  logic signed [23:0] dx_sq, dy_sq;
  logic signed [25:0] ex_sq, ey_sq;
  logic [9:0]         ro;
  logic [11:0]        ri;

  always_comb begin
    dx_sq = s2_dx_q * s2_dx_q;
    dy_sq = s2_dy_q * s2_dy_q;
    ex_sq = s2_ex_q * s2_ex_q;
    ey_sq = s2_ey_q * s2_ey_q;
    ro    = {5'd0, s2_outer_q} * {5'd0, s2_outer_q};
    ri    = {6'd0, s2_inner_q} * {6'd0, s2_inner_q};
  end

  // ---------------- Stage 3: distance compare, table access ----------------
  logic         s3_vld_q;
  khm_pkg::op_e s3_op_q;
  logic         s3_key_ok_q, s3_pix_in_q;
  logic [21:0]  s3_dx2_q, s3_dy2_q;
  logic [22:0]  s3_ex2_q, s3_ey2_q;
  logic [9:0]   s3_ro_q;
  logic [11:0]  s3_ri_q;
  logic [9:0]   s3_tidx_q;
  logic         s3_tok_q;
  logic [15:0]  s3_tval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      s3_op_q     <= s2_op_q;
      s3_key_ok_q <= s2_key_ok_q;
      s3_pix_in_q <= s2_pix_in_q;
      s3_dx2_q    <= dx_sq[21:0];
      s3_dy2_q    <= dy_sq[21:0];
      s3_ex2_q    <= ex_sq[22:0];
      s3_ey2_q    <= ey_sq[22:0];
      s3_ro_q     <= ro;
      s3_ri_q     <= ri;
      s3_tidx_q   <= s2_tidx_q;
      s3_tok_q    <= s2_tok_q;
      s3_tval_q   <= s2_tval_q;
    end
  end

  logic [22:0]     d2;
  logic [23:0]     gidx_full;
  logic [TbAw-1:0] gidx;
  logic            in_disk, in_ring;
  logic [15:0]     gauss_rdata;

  always_comb begin
    d2        = {1'b0, s3_dx2_q} + {1'b0, s3_dy2_q};
    gidx_full = {1'b0, s3_ex2_q} + {1'b0, s3_ey2_q};
    gidx      = (gidx_full > 24'(TABLE_DEPTH - 1)) ? TbAw'(TABLE_DEPTH - 1) : TbAw'(gidx_full);
    in_disk   = d2 <= {13'd0, s3_ro_q};
    in_ring   = d2 < {11'd0, s3_ri_q};
  end

  // Table writes are made at this stage too, so reads and writes of the
  // table keep the order of the requests.
  khm_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH),
    .AW    (TbAw)
  ) u_gauss_ram (
    .clk_i   (clk_i),
    .we_i    (s3_vld_q && s3_op_q == khm_pkg::OP_WRITE_TABLE && s3_tok_q),
    .waddr_i (TbAw'(s3_tidx_q)),
    .wdata_i (s3_tval_q),
    .re_i    (s3_vld_q && s3_op_q == khm_pkg::OP_EVAL),
    .raddr_i (gidx),
    .rdata_o (gauss_rdata)
  );

  // ---------------- Stage 4: result select ----------------
  logic s4_vld_q;
  logic s4_key_ok_q, s4_pix_in_q, s4_in_disk_q, s4_in_ring_q;
  res_t res_item;
  logic push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q && s3_op_q == khm_pkg::OP_EVAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      s4_key_ok_q  <= s3_key_ok_q;
      s4_pix_in_q  <= s3_pix_in_q;
      s4_in_disk_q <= in_disk;
      s4_in_ring_q <= in_ring;
    end
  end

  always_comb begin
    res_item.heat  = 16'd0;
    res_item.mask  = 1'b0;
    res_item.valid = 1'b0;
    if (s4_key_ok_q) begin
      res_item.valid = 1'b1;
      res_item.mask  = 1'b1;
      if (s4_pix_in_q) begin
        if (s4_in_disk_q) begin
          res_item.heat = binary_mode_i ? 16'hFFFF : gauss_rdata;
        end else if (s4_in_ring_q) begin
          res_item.mask = 1'b0;
        end
      end
    end
  end

  assign push = s4_vld_q;

  // ---------------- Result queue ----------------
  res_t             ofifo_q [khm_pkg::OUT_DEPTH];
  logic [OutAw-1:0] owr_ptr_q, ord_ptr_q;
  logic [OutCw-1:0] ofifo_cnt_q, ofifo_cnt_d;
  logic             pop;
  res_t             head;

  assign out_valid_o  = ofifo_cnt_q != '0;
  assign pop          = out_valid_o && out_ready_i;
  assign head         = ofifo_q[ord_ptr_q];
  assign heat_value_o = head.heat;
  assign mask_bit_o   = head.mask;
  assign key_valid_o  = head.valid;

  always_comb begin
    case ({push, pop})
      2'b10:   ofifo_cnt_d = ofifo_cnt_q + 1'b1;
      2'b01:   ofifo_cnt_d = ofifo_cnt_q - 1'b1;
      default: ofifo_cnt_d = ofifo_cnt_q;
    endcase
    case ({issue_eval, pop})
      2'b10:   res_d = res_q + 1'b1;
      2'b01:   res_d = res_q - 1'b1;
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_ptr_q   <= '0;
      ord_ptr_q   <= '0;
      ofifo_cnt_q <= '0;
      res_q       <= '0;
    end else begin
      if (push) begin
        owr_ptr_q <= owr_ptr_q + 1'b1;
      end
      if (pop) begin
        ord_ptr_q <= ord_ptr_q + 1'b1;
      end
      ofifo_cnt_q <= ofifo_cnt_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ofifo_q[owr_ptr_q] <= res_item;
    end
  end

  `KHM_ASSERT(a_res_bound, res_q <= OutCw'(khm_pkg::OUT_DEPTH), "reservations exceed queue")
  `KHM_ASSERT(a_fifo_le_res, ofifo_cnt_q <= res_q, "queued results exceed reservations")
  `KHM_ASSERT(a_eval_lands, issue_eval |-> ##4 push, "pixel request did not reach queue")
  `KHM_ASSERT_NEVER(a_no_overflow, push && !pop && ofifo_cnt_q == OutCw'(khm_pkg::OUT_DEPTH), "result queue overflow")

endmodule

`default_nettype wire

[rtl/keypoint_heatmap_mask_render.sv]
// Path: an accepted pixel request passes through the command queue, the back-end stages and
// the result queue write; out_valid_o then rises for its result.
// Throughput: one request per cycle, set by the single-issue back-end pipeline. Pixel requests
// hold back only when eight pixel results are in flight or waiting untaken in the result queue.
// Reset (asynchronous, active low) empties both queues, sets the image size to full scale
// and clears both registers; the keypoint slots and table words hold nothing until written.
`timescale 1ns / 1ps
`default_nettype none

module keypoint_heatmap_mask_render #(
  parameter int unsigned KEYPOINTS   = khm_pkg::KEYPOINTS,
  parameter int unsigned TABLE_DEPTH = khm_pkg::TABLE_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [khm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [khm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       opcode_i,
  input  wire logic [3:0]                       key_index_i,
  input  wire logic signed [10:0]               pos_x_i,
  input  wire logic signed [10:0]               pos_y_i,
  input  wire logic [10:0]                      image_width_i,
  input  wire logic [10:0]                      image_height_i,
  input  wire logic [4:0]                       outer_radius_i,
  input  wire logic [5:0]                       inner_radius_i,
  input  wire logic [9:0]                       table_index_i,
  input  wire logic [15:0]                      table_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [15:0]                           heat_value_o,
  output logic                                  mask_bit_o,
  output logic                                  key_valid_o
);

  logic              binary_mode_q, binary_mode_d;
  logic signed [4:0] gauss_mean_q, gauss_mean_d;
  logic              cmd_valid, cmd_ready;
  khm_pkg::cmd_t     cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    binary_mode_d = binary_mode_q;
    gauss_mean_d  = gauss_mean_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        khm_pkg::CFG_BINARY_MODE: binary_mode_d = cfg_data_i[0];
        khm_pkg::CFG_GAUSS_MEAN:  gauss_mean_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_mode_q <= 1'b0;
      gauss_mean_q  <= '0;
    end else begin
      binary_mode_q <= binary_mode_d;
      gauss_mean_q  <= gauss_mean_d;
    end
  end

  khm_front #(
    .KEYPOINTS   (KEYPOINTS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .key_index_i    (key_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .image_width_i  (image_width_i),
    .image_height_i (image_height_i),
    .outer_radius_i (outer_radius_i),
    .inner_radius_i (inner_radius_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  khm_back #(
    .KEYPOINTS   (KEYPOINTS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .binary_mode_i (binary_mode_q),
    .gauss_mean_i  (gauss_mean_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .heat_value_o  (heat_value_o),
    .mask_bit_o    (mask_bit_o),
    .key_valid_o   (key_valid_o)
  );

endmodule

`default_nettype wire
